// File: rtl/kwsc_pkg.sv
package kwsc_pkg;

  localparam int KEY_LEN = 5;
  localparam int ALPHA = 26;
  localparam int LTR_W = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] UPPER_A = 8'd65;
  localparam logic [7:0] UPPER_Z = 8'd90;
  localparam logic [7:0] LOWER_A = 8'd97;
  localparam logic [7:0] LOWER_Z = 8'd122;

  typedef logic [LTR_W-1:0] kwsc_ltr_t;
  typedef kwsc_ltr_t [KEY_LEN-1:0] kwsc_key_t;
  typedef kwsc_ltr_t [ALPHA-1:0] kwsc_pos_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } kwsc_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       key_bad;
  } kwsc_out_t;

  // cipher alphabet view of the key: position of every plain letter, key check
  typedef struct packed {
    kwsc_pos_t pos;
    logic      bad;
  } kwsc_alpha_t;

endpackage

// File: rtl/keyword_substitution_cipher.sv
// Keyword substitution cipher, one ASCII byte per word.
// Input: assert start with din (mode, char_in); the word is taken at a
// rising edge where start is high and busy is low. busy is high only while
// rst is high, so a word can be given every cycle.
// Output: done pulses for one cycle with dout (char_out, key_bad). There is
// no back-pressure; the receiver must take each word in that cycle.
// The path holds one input register and one result register. Throughput is
// one word per cycle, set by the single mapping stage between those
// registers.
// Letters of either case come out lower case; other bytes pass unchanged.
// With a repeated key letter or one above z, key_bad is set and letters
// pass unchanged apart from case folding.
// Key letters sit on the APB port at byte addresses 0, 4, 8, 12, 16; write
// them only while no word is in flight.
// Reset (synchronous) drops words in flight and loads the key "abcde".
module keyword_substitution_cipher
  import kwsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kwsc_in_t          din,
  output logic              done,
  output kwsc_out_t         dout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  kwsc_key_t   keys;
  kwsc_alpha_t alpha;

  assign busy   = rst;
  assign pready = 1'b1;

  kwsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .keys    (keys)
  );

  kwsc_alpha u_alpha (
    .keys  (keys),
    .alpha (alpha)
  );

  kwsc_xlate u_xlate (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .din    (din),
    .alpha  (alpha),
    .done   (done),
    .dout   (dout)
  );

endmodule

// File: rtl/kwsc_regs.sv
module kwsc_regs
  import kwsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output kwsc_key_t         keys
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        keys[i] <= LTR_W'(i);
      end
    end else if (wr_en && (32'(reg_idx) < 32'(KEY_LEN))) begin
      keys[reg_idx] <= pwdata[LTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) < 32'(KEY_LEN)) begin
      prdata = DATA_W'(keys[reg_idx]);
    end
  end

endmodule

// File: rtl/kwsc_alpha.sv
module kwsc_alpha
  import kwsc_pkg::*;
(
  input  kwsc_key_t   keys,
  output kwsc_alpha_t alpha
);

  always_comb begin
    logic                bad;
    logic                hit;
    logic [LTR_W-1:0]    hit_pos;
    logic [2:0]          lt_cnt;
    logic [LTR_W:0]      rest_pos;

    bad = 1'b0;
    for (int i = 0; i < KEY_LEN; i++) begin
      if (32'(keys[i]) >= ALPHA) bad = 1'b1;
      for (int j = i + 1; j < KEY_LEN; j++) begin
        if (keys[i] == keys[j]) bad = 1'b1;
      end
    end

    for (int c = 0; c < ALPHA; c++) begin
      hit     = 1'b0;
      hit_pos = '0;
      lt_cnt  = '0;
      for (int j = KEY_LEN - 1; j >= 0; j--) begin
        if (keys[j] == LTR_W'(c)) begin
          hit     = 1'b1;
          hit_pos = LTR_W'(j);
        end
        if (keys[j] < LTR_W'(c)) lt_cnt = lt_cnt + 3'd1;
      end
      // unused letters follow the key in alphabetical order
      rest_pos = (LTR_W+1)'(KEY_LEN + c) - (LTR_W+1)'(lt_cnt);
      alpha.pos[c] = hit ? hit_pos : rest_pos[LTR_W-1:0];
    end
    alpha.bad = bad;
  end

endmodule

// File: rtl/kwsc_xlate.sv
module kwsc_xlate
  import kwsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  kwsc_in_t    din,
  input  kwsc_alpha_t alpha,
  output logic        done,
  output kwsc_out_t   dout
);

  logic      in_vld;
  kwsc_in_t  in_q;
  kwsc_out_t dout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= accept;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= din;
    if (in_vld) dout <= dout_next;
  end

  always_comb begin
    logic             is_up;
    logic             is_low;
    logic [7:0]       diff;
    logic [LTR_W-1:0] idx;
    logic [LTR_W-1:0] enc;
    logic [LTR_W-1:0] res;

    is_up  = (in_q.char_in >= UPPER_A) && (in_q.char_in <= UPPER_Z);
    is_low = (in_q.char_in >= LOWER_A) && (in_q.char_in <= LOWER_Z);
    diff   = in_q.char_in - (is_up ? UPPER_A : LOWER_A);
    idx    = diff[LTR_W-1:0];

    enc = '0;
    for (int c = 0; c < ALPHA; c++) begin
      if (alpha.pos[c] == idx) enc = enc | LTR_W'(c);
    end

    if (alpha.bad) res = idx;
    else if (in_q.mode) res = alpha.pos[idx];
    else res = enc;

    dout_next.key_bad  = alpha.bad;
    dout_next.char_out = (is_up || is_low) ? (LOWER_A + 8'(res)) : in_q.char_in;
  end

endmodule

// File: rtl/kwsc_checker.sv
module kwsc_checker
  import kwsc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input kwsc_in_t  din,
  input logic      done,
  input kwsc_out_t dout
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted word produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  a_char_form: assert property (@(posedge clk) disable iff (rst)
    done |-> (dout.char_out == $past(din.char_in, 2)) ||
             ((dout.char_out >= LOWER_A) && (dout.char_out <= LOWER_Z)))
    else $error("result is neither passthrough nor lower case letter");

endmodule

bind keyword_substitution_cipher kwsc_checker u_chk (.*);
